// File: hdl/arw_pkg.sv
// ============================================================================
// arw_pkg
// Shared types and verdict codes of the anti-replay window.
// ============================================================================
package arw_pkg;

    localparam int SEQ_W     = 64;
    localparam int VERDICT_W = 2;

    typedef logic [SEQ_W-1:0]     seq_t;
    typedef logic [VERDICT_W-1:0] verdict_t;

    localparam verdict_t VERDICT_ACCEPT = 2'd0;
    localparam verdict_t VERDICT_DUP    = 2'd1;
    localparam verdict_t VERDICT_OLD    = 2'd2;

    // One registered packet that the window checks in this cycle.
    typedef struct packed {
        logic valid;
        seq_t seq_num;
    } step_t;

endpackage

// File: hdl/arw_seq_if.sv
// ============================================================================
// arw_seq_if
// Valid/ready channel that carries one packet sequence number per item.
// ============================================================================
interface arw_seq_if;
    import arw_pkg::*;

    logic valid;
    logic ready;
    seq_t seq_num;

    modport source (output valid, output seq_num, input ready);
    modport sink   (input valid, input seq_num, output ready);
endinterface

// File: hdl/arw_verdict_if.sv
// ============================================================================
// arw_verdict_if
// Valid/ready channel that carries one replay verdict per item.
// ============================================================================
interface arw_verdict_if;
    import arw_pkg::*;

    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// File: hdl/arw_window.sv
// ============================================================================
// arw_window
// Window state (highest number, seeded flag, bitmap) and the per-packet
// decision; the decision is combinational, the state is registered.
// ============================================================================
module arw_window #(
    parameter int WINDOW_BITS = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  arw_pkg::step_t    step,
    output arw_pkg::verdict_t verdict
);
    import arw_pkg::*;

    localparam int   IDX_W       = $clog2(WINDOW_BITS);
    localparam seq_t WINDOW_SIZE = SEQ_W'(WINDOW_BITS);

    seq_t                   highest_seen_reg, highest_seen_next;
    logic                   seeded_reg, seeded_next;
    logic [WINDOW_BITS-1:0] bitmap_reg, bitmap_next;

    logic             newer;
    seq_t             advance;
    seq_t             offset;
    logic [IDX_W-1:0] offset_idx;

    assign newer      = step.seq_num > highest_seen_reg;
    assign advance    = step.seq_num - highest_seen_reg;
    assign offset     = highest_seen_reg - step.seq_num;
    assign offset_idx = offset[IDX_W-1:0];

    always_comb
    begin
        highest_seen_next = highest_seen_reg;
        seeded_next       = seeded_reg;
        bitmap_next       = bitmap_reg;
        verdict           = VERDICT_ACCEPT;
        if (!seeded_reg)
        begin
            highest_seen_next = step.seq_num;
            seeded_next       = 1'b1;
            bitmap_next       = '0;
            bitmap_next[0]    = 1'b1;
        end
        else if (newer)
        begin
            // Bits shifted past the top of the window simply fall off.
            if (advance >= WINDOW_SIZE)
            begin
                bitmap_next = '0;
            end
            else
            begin
                bitmap_next = bitmap_reg << advance[IDX_W-1:0];
            end
            bitmap_next[0]    = 1'b1;
            highest_seen_next = step.seq_num;
        end
        else if (offset >= WINDOW_SIZE)
        begin
            verdict = VERDICT_OLD;
        end
        else if (bitmap_reg[offset_idx])
        begin
            verdict = VERDICT_DUP;
        end
        else
        begin
            bitmap_next[offset_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_seen_reg <= '0;
            seeded_reg       <= 1'b0;
            bitmap_reg       <= '0;
        end
        else if (step.valid)
        begin
            highest_seen_reg <= highest_seen_next;
            seeded_reg       <= seeded_next;
            bitmap_reg       <= bitmap_next;
        end
    end

`ifndef SYNTHESIS
    // Once seeded, the highest accepted number is always marked.
    a_top_marked: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |-> bitmap_reg[0])
        else $error("window seeded but offset zero not marked");

    a_empty_unseeded: assert property (@(posedge clk) disable iff (!rst_n)
        !seeded_reg |-> (bitmap_reg == '0))
        else $error("bitmap not empty before the first packet");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step.valid && verdict != VERDICT_ACCEPT) |=>
            ($stable(highest_seen_reg) && $stable(bitmap_reg) && $stable(seeded_reg)))
        else $error("rejected packet changed the window state");

    a_highest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (step.valid && seeded_reg) |=> (highest_seen_reg >= $past(highest_seen_reg)))
        else $error("highest accepted number moved backward");
`endif

endmodule

// File: hdl/anti_replay_window.sv
// ============================================================================
// anti_replay_window
// Sliding-window replay check on the sequence numbers of authenticated packets.
// ============================================================================
// Usage:
//   packet (sink) takes one 64-bit sequence number per item; result (source)
//   returns one 2-bit verdict per item, in order: accepted, duplicate, or
//   too old (behind the window).
//   An accepted item lands in the input register; once the result register
//   can advance, the window logic decides it, updates the state and loads
//   the result register, from which the verdict is taken. One item is
//   accepted every cycle while result.ready is high.
//   The cycle time is set by the WINDOW_BITS-wide barrel shift of the bitmap
//   and the 64-bit compare against the highest accepted number, which form
//   the loop from the window state back into itself.
//   Reset clears the window (the next packet seeds it) and empties both
//   registers. When the receiver stalls, the verdict is held, one more item
//   waits in the input register, and packet.ready then drops until the
//   verdict is taken.
// ============================================================================
module anti_replay_window #(
    parameter int WINDOW_BITS = 2048
) (
    input logic           clk,
    input logic           rst_n,
    arw_seq_if.sink       packet,
    arw_verdict_if.source result
);
    import arw_pkg::*;

    logic     in_valid_reg, in_valid_next;
    seq_t     seq_reg;
    logic     res_valid_reg, res_valid_next;
    verdict_t verdict_reg;

    logic     advance;
    logic     in_take;
    step_t    step;
    verdict_t verdict;

    assign advance      = !res_valid_reg || result.ready;
    assign packet.ready = !in_valid_reg || advance;
    assign in_take      = packet.valid && packet.ready;

    assign step.valid   = in_valid_reg && advance;
    assign step.seq_num = seq_reg;

    arw_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .verdict (verdict)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step.valid)
        begin
            in_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (step.valid)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            seq_reg <= packet.seq_num;
        end
        if (step.valid)
        begin
            verdict_reg <= verdict;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.verdict = verdict_reg;

endmodule
